FILE: rtl/core/neighbor_table_with_aging_unit_macros.svh
// Assertion macros used by the checker file of the neighbour table.
`ifndef NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nta_pkg.sv
// Shared types, constants and helpers of the neighbour table with aging.
package nta_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int NUM_IFACES    = 4;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int IFACE_W       = 2;
    localparam int ID_W          = 32;
    localparam int COUNT_W       = 6;
    localparam int AGE_W         = 10;
    localparam int HELLO_W       = 8;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 16;

    localparam logic [HELLO_W-1:0] HELLO_RESET = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [AGE_W-1:0]   AGE_MAX     = '1;

    localparam logic MODE_HELLO = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_REFRESHED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TICK      = 2'd3;

    // Stored neighbour description, interface in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]    mask;
        logic [ID_W-1:0]    addr;
        logic [ID_W-1:0]    router;
        logic [IFACE_W-1:0] iface;
    } t_entry_info;

    localparam int INFO_W = $bits(t_entry_info);

    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [ENTRY_W-1:0] rd_addr;
        logic               commit;
        logic               emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic iface_ok(input logic [IFACE_W-1:0] ifc);
        return (32'(ifc) < NUM_IFACES);
    endfunction

endpackage

FILE: rtl/core/nta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/nta_ctrl.sv
// Sequencer that walks the table once per request and hands over the result.
module nta_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nta_pkg::t_stat i_stat,
    output nta_pkg::t_cmd  o_cmd
);

    import nta_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(TABLE_ENTRIES - 1);

    t_state             r_state, n_state;
    logic [ENTRY_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_addr = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_cnt == LAST_ENTRY) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/nta_dp.sv
// Datapath: entry stores, valid bits, interface counts, scan tracking and result register.
module nta_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nta_pkg::t_cmd                   i_cmd,
    output nta_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_we,
    input  logic [nta_pkg::HELLO_W-1:0]     i_cfg_wdata,
    input  logic                            i_mode,
    input  logic [nta_pkg::IFACE_W-1:0]     i_iface,
    input  logic [nta_pkg::ID_W-1:0]        i_router,
    input  logic [nta_pkg::ID_W-1:0]        i_addr,
    input  logic [nta_pkg::ID_W-1:0]        i_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nta_pkg::STATUS_W-1:0]    o_status,
    output logic [nta_pkg::COUNT_W-1:0]     o_neighbors,
    output logic [nta_pkg::COUNT_W-1:0]     o_removed
);

    import nta_pkg::*;

    // Request captured at acceptance.
    logic               r_mode;
    logic [IFACE_W-1:0] r_ifc;
    logic [ID_W-1:0]    r_rid, r_sip, r_msk;

    logic [HELLO_W-1:0]      r_hello;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [COUNT_W-1:0]      r_count [NUM_IFACES];

    // Entry whose stored data arrives from the RAMs in this cycle.
    logic               r_proc;
    logic [ENTRY_W-1:0] r_pidx;

    logic               r_hit, r_free;
    logic [ENTRY_W-1:0] r_hit_idx, r_free_idx;
    logic [COUNT_W-1:0] r_removed;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_nbr, r_out_removed;

    t_entry_info        w_info_rd, w_info_wr;
    logic [AGE_W-1:0]   w_age_rd, w_age_new, w_age_wdata;
    logic [AGE_W-1:0]   w_limit;
    logic               w_info_we, w_age_we;
    logic [ENTRY_W-1:0] w_age_waddr;
    logic               w_pvalid, w_match, w_die;
    logic               w_do_add, w_do_refresh;
    logic [STATUS_W-1:0] w_status;

    nta_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_ENTRIES)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (w_info_we),
        .i_waddr (r_free_idx),
        .i_wdata (w_info_wr),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_info_rd)
    );

    nta_ram #(.WIDTH(AGE_W), .DEPTH(TABLE_ENTRIES)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (w_age_waddr),
        .i_wdata (w_age_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_age_rd)
    );

    // Dead limit is three hello intervals.
    assign w_limit   = {1'b0, r_hello, 1'b0} + {2'b00, r_hello};
    assign w_pvalid  = r_proc && r_valid[r_pidx];
    assign w_match   = (w_info_rd.iface == r_ifc) && (w_info_rd.router == r_rid);
    assign w_age_new = (w_age_rd < AGE_MAX) ? (w_age_rd + 1'b1) : w_age_rd;
    assign w_die     = (r_mode == MODE_TICK) && w_pvalid && (w_age_new > w_limit);

    assign w_do_refresh = i_cmd.commit && (r_mode == MODE_HELLO) && iface_ok(r_ifc) && r_hit;
    assign w_do_add     = i_cmd.commit && (r_mode == MODE_HELLO) && iface_ok(r_ifc)
                          && !r_hit && r_free;

    assign w_info_we = w_do_add;
    assign w_info_wr = '{mask: r_msk, addr: r_sip, router: r_rid, iface: r_ifc};

    always_comb begin
        w_age_we    = 1'b0;
        w_age_waddr = r_pidx;
        w_age_wdata = w_age_new;
        priority if (w_do_refresh) begin
            w_age_we    = 1'b1;
            w_age_waddr = r_hit_idx;
            w_age_wdata = '0;
        end else if (w_do_add) begin
            w_age_we    = 1'b1;
            w_age_waddr = r_free_idx;
            w_age_wdata = '0;
        end else if ((r_mode == MODE_TICK) && w_pvalid && !w_die) begin
            w_age_we = 1'b1;
        end
    end

    always_comb begin
        priority if (r_mode == MODE_TICK) begin
            w_status = STAT_TICK;
        end else if (!iface_ok(r_ifc)) begin
            w_status = STAT_DROPPED;
        end else if (r_hit) begin
            w_status = STAT_REFRESHED;
        end else if (r_free) begin
            w_status = STAT_ADDED;
        end else begin
            w_status = STAT_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_ifc  <= i_iface;
            r_rid  <= i_router;
            r_sip  <= i_addr;
            r_msk  <= i_mask;
        end
        r_pidx <= i_cmd.rd_addr;
        if (r_proc && (r_mode == MODE_HELLO)) begin
            if (w_pvalid && w_match && !r_hit) begin
                r_hit_idx <= r_pidx;
            end
            if (!r_valid[r_pidx] && !r_free) begin
                r_free_idx <= r_pidx;
            end
        end
        if (i_cmd.emit) begin
            r_out_status  <= w_status;
            r_out_nbr     <= iface_ok(r_ifc) ? r_count[r_ifc] : '0;
            r_out_removed <= r_removed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hello     <= HELLO_RESET;
            r_valid     <= '0;
            r_proc      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_IFACES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_hello <= i_cfg_wdata;
            end
            r_proc <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
                r_removed <= '0;
            end
            if (r_proc && (r_mode == MODE_HELLO)) begin
                if (w_pvalid && w_match) begin
                    r_hit <= 1'b1;
                end
                if (!r_valid[r_pidx]) begin
                    r_free <= 1'b1;
                end
            end
            if (w_die) begin
                r_valid[r_pidx] <= 1'b0;
                if (iface_ok(w_info_rd.iface) && (r_count[w_info_rd.iface] != '0)) begin
                    r_count[w_info_rd.iface] <= r_count[w_info_rd.iface] - 1'b1;
                end
                if (r_removed != COUNT_MAX) begin
                    r_removed <= r_removed + 1'b1;
                end
            end
            if (w_do_add) begin
                r_valid[r_free_idx] <= 1'b1;
                if (r_count[r_ifc] != COUNT_MAX) begin
                    r_count[r_ifc] <= r_count[r_ifc] + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_neighbors     = r_out_nbr;
    assign o_removed       = r_out_removed;

endmodule

FILE: rtl/core/neighbor_table_with_aging_unit.sv
// Top level of the neighbour table with dead-timer aging.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: mode; tdata: interface, router id, source, mask
//  m_axis    out        tuser: status; tdata: neighbour count, removed count
//  i_cfg     in         hello interval, written with i_cfg_we
//
// Every request walks all 32 table entries, one per cycle, through the RAM read
// port, and then passes through the drain, commit and result states.
// A new request is taken only in idle, which the sweep sets as the rate.
// Reset clears the valid bits and counts at once; no clearing pass is needed.
// A result waits in the output register while the next request is taken.
module neighbor_table_with_aging_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: iface_index[1:0], neighbour_id[33:2], source_ip[65:34],
    // net_mask[97:66], zero fill [103:98]
    input  logic [nta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: iface_neighbors[5:0], removed_count[11:6], zero fill [15:12]
    output logic [nta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: status
    output logic [nta_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [nta_pkg::HELLO_W-1:0]       i_cfg_wdata
);

    import nta_pkg::*;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic [COUNT_W-1:0] w_neighbors, w_removed;

    nta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nta_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (s_axis_tuser),
        .i_iface     (s_axis_tdata[1:0]),
        .i_router    (s_axis_tdata[33:2]),
        .i_addr      (s_axis_tdata[65:34]),
        .i_mask      (s_axis_tdata[97:66]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_neighbors (w_neighbors),
        .o_removed   (w_removed)
    );

    assign m_axis_tdata = {4'b0000, w_removed, w_neighbors};

endmodule

FILE: rtl/core/nta_checker.sv
// Port-level checker for the neighbour table, bound to the top level.
`include "neighbor_table_with_aging_unit_macros.svh"

module nta_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [nta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [nta_pkg::STATUS_W-1:0]      m_axis_tuser
);

    import nta_pkg::*;

    // A stalled result must not change.
    `NTA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    // Only one request is in work at a time, so the input closes after acceptance.
    `NTA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
    // A hello never removes entries.
    `NTA_ASSERT_SAME(a_hello_no_removal, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != STAT_TICK), m_axis_tdata[11:6] == '0, "hello reported removals")
    // An added neighbour is counted on its interface.
    `NTA_ASSERT_SAME(a_added_counted, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == STAT_ADDED), m_axis_tdata[5:0] != '0, "added neighbour not counted")
    // Neither count can exceed the table size.
    `NTA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, m_axis_tvalid, (32'(m_axis_tdata[5:0]) <= TABLE_ENTRIES) && (32'(m_axis_tdata[11:6]) <= TABLE_ENTRIES), "count beyond table size")

endmodule

bind neighbor_table_with_aging_unit nta_checker u_nta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
